// ===== hdl/npc_pkg.sv =====
`timescale 1ns / 1ps

package npc_pkg;

	localparam int IDX_W     = 4;
	localparam int CNT_W     = 5;
	localparam int CH_W      = 8;
	localparam int SQ_W      = 2 * CH_W;
	localparam int DIST_W    = 18;
	localparam int COLOR_W   = 3 * CH_W;
	localparam int MAX_SLOTS = 16;

	localparam logic OP_WRITE    = 1'b0;
	localparam logic OP_CLASSIFY = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] idx;
	} tag_t;

endpackage

// ===== hdl/npc_palette_ram.sv =====
`timescale 1ns / 1ps

module npc_palette_ram #(
	parameter int DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [npc_pkg::COLOR_W-1:0] wdata,
	input  logic                       re,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic [npc_pkg::COLOR_W-1:0] rdata
);
	import npc_pkg::*;

	logic [COLOR_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/npc_dist_unit.sv =====
`timescale 1ns / 1ps

module npc_dist_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  npc_pkg::tag_t               tag_s1,
	input  logic [npc_pkg::COLOR_W-1:0] entry_s1,
	input  logic [npc_pkg::CH_W-1:0]    pix_r,
	input  logic [npc_pkg::CH_W-1:0]    pix_g,
	input  logic [npc_pkg::CH_W-1:0]    pix_b,
	output npc_pkg::tag_t               tag_s2,
	output logic [npc_pkg::DIST_W-1:0]  dist_s2
);
	import npc_pkg::*;

	logic [CH_W-1:0] ent_r, ent_g, ent_b;
	logic [CH_W-1:0] dr, dg, db;
	logic [SQ_W-1:0] sq_r_s2, sq_g_s2, sq_b_s2;

	assign ent_r = entry_s1[3*CH_W-1:2*CH_W];
	assign ent_g = entry_s1[2*CH_W-1:CH_W];
	assign ent_b = entry_s1[CH_W-1:0];

	assign dr = (pix_r > ent_r) ? (pix_r - ent_r) : (ent_r - pix_r);
	assign dg = (pix_g > ent_g) ? (pix_g - ent_g) : (ent_g - pix_g);
	assign db = (pix_b > ent_b) ? (pix_b - ent_b) : (ent_b - pix_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else begin
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		sq_r_s2 <= SQ_W'(dr) * SQ_W'(dr);
		sq_g_s2 <= SQ_W'(dg) * SQ_W'(dg);
		sq_b_s2 <= SQ_W'(db) * SQ_W'(db);
	end

	assign dist_s2 = DIST_W'(sq_r_s2) + DIST_W'(sq_g_s2) + DIST_W'(sq_b_s2);

endmodule

// ===== hdl/nearest_palette_color.sv =====
// Write item: no result; input stays ready after a write.
// Classify item: with n the searched count (palette_count capped at the palette depth), the
// search issues n palette memory reads, one read and one compare per cycle, through a
// read, squared-distance and compare pipeline; the result loads once the previous result is taken.
// One item at a time: input is not ready again until the classify result is loaded.
// Reset clears control and palette_count; palette contents are undefined until written.
`timescale 1ns / 1ps

module nearest_palette_color #(
	parameter int NUM_ENTRIES = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [npc_pkg::CNT_W-1:0]  cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       op,
	input  logic [npc_pkg::IDX_W-1:0]  entry_index,
	input  logic [npc_pkg::CH_W-1:0]   red_in,
	input  logic [npc_pkg::CH_W-1:0]   green_in,
	input  logic [npc_pkg::CH_W-1:0]   blue_in,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [npc_pkg::IDX_W-1:0]  nearest_index,
	output logic                       no_match,
	output logic [npc_pkg::DIST_W-1:0] nearest_dist_sq
);
	import npc_pkg::*;

	localparam int SLOTS = (NUM_ENTRIES < MAX_SLOTS) ? NUM_ENTRIES : MAX_SLOTS;
	localparam int AW    = $clog2(SLOTS);

	state_t state_q, state_d;

	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   n_q;
	logic [CNT_W-1:0]   issue_cnt_q;
	logic [CH_W-1:0]    pix_r_q, pix_g_q, pix_b_q;
	logic               found_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [DIST_W-1:0]  best_dist_q;
	logic               out_valid_q;
	logic [IDX_W-1:0]   out_idx_q;
	logic               out_nm_q;
	logic [DIST_W-1:0]  out_dist_q;

	logic               in_xfer, wr_en, wr_slot_ok, rd_en, search_done, load_out;
	logic [CNT_W-1:0]   n_clamp;
	logic [COLOR_W-1:0] rd_data;
	tag_t               tag_s1_q, tag_s2;
	logic [DIST_W-1:0]  dist_s2;
	logic               better;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_valid) begin
			count_q <= cfg_data;
		end
	end

	assign in_xfer    = in_valid && in_ready;
	assign wr_slot_ok = {1'b0, entry_index} < CNT_W'(SLOTS);
	assign wr_en      = in_xfer && (op == OP_WRITE) && wr_slot_ok;
	assign n_clamp    = (count_q > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : count_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer && op == OP_CLASSIFY) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (search_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		rd_en       = 1'b0;
		search_done = 1'b0;
		load_out    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_SEARCH: begin
				rd_en       = issue_cnt_q < n_q;
				search_done = (issue_cnt_q == n_q) && !tag_s1_q.valid && !tag_s2.valid;
			end
			ST_FINISH: begin
				load_out = !out_valid_q || out_ready;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			tag_s1_q <= '0;
		end else begin
			state_q        <= state_d;
			tag_s1_q.valid <= rd_en;
			tag_s1_q.idx   <= issue_cnt_q[IDX_W-1:0];
		end
	end

	npc_palette_ram #(
		.DEPTH(SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (entry_index[AW-1:0]),
		.wdata ({red_in, green_in, blue_in}),
		.re    (rd_en),
		.raddr (issue_cnt_q[AW-1:0]),
		.rdata (rd_data)
	);

	npc_dist_unit u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.tag_s1   (tag_s1_q),
		.entry_s1 (rd_data),
		.pix_r    (pix_r_q),
		.pix_g    (pix_g_q),
		.pix_b    (pix_b_q),
		.tag_s2   (tag_s2),
		.dist_s2  (dist_s2)
	);

	// strict less-than keeps the lower index on a tie
	assign better = tag_s2.valid && (!found_q || dist_s2 < best_dist_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_cnt_q <= '0;
			n_q         <= '0;
			found_q     <= 1'b0;
		end else if (in_xfer && op == OP_CLASSIFY) begin
			issue_cnt_q <= '0;
			n_q         <= n_clamp;
			found_q     <= 1'b0;
		end else begin
			if (rd_en) begin
				issue_cnt_q <= issue_cnt_q + 1'b1;
			end
			if (better) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && op == OP_CLASSIFY) begin
			pix_r_q     <= red_in;
			pix_g_q     <= green_in;
			pix_b_q     <= blue_in;
			best_idx_q  <= '0;
			best_dist_q <= '0;
		end else if (better) begin
			best_idx_q  <= tag_s2.idx;
			best_dist_q <= dist_s2;
		end
	end

	// hold the result until transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_idx_q  <= best_idx_q;
			out_nm_q   <= !found_q;
			out_dist_q <= best_dist_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign nearest_index   = out_idx_q;
	assign no_match        = out_nm_q;
	assign nearest_dist_sq = out_dist_q;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import npc_pkg::*;

	localparam int     NUM_ENTRIES   = 16;
	localparam int     CLK_PERIOD    = 8;
	localparam int     SETTLE_CYCLES = 32;
	localparam int     HOLD_CYCLES   = 400;
	localparam int     PHASE_ITEMS   = 155;
	localparam longint CYCLE_LIMIT   = 500000;

	typedef struct packed {
		logic [IDX_W-1:0]  index;
		logic              none;
		logic [DIST_W-1:0] dist_sq;
	} match_t;

	class palette_mirror;
		logic [COLOR_W-1:0] entries [NUM_ENTRIES];
		logic [CNT_W-1:0]   count = '0;
		match_t             pending_matches [$];
		int unsigned        failures = 0;

		function void set_count(logic [CNT_W-1:0] value);
			count = value;
		endfunction

		function int unsigned searched();
			int unsigned limit;
			limit = 32'(count);
			if (limit > NUM_ENTRIES)
				limit = NUM_ENTRIES;
			if (limit > MAX_SLOTS)
				limit = MAX_SLOTS;
			return limit;
		endfunction

		function match_t nearest_entry(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
				logic [CH_W-1:0] b);
			match_t      m;
			int unsigned limit, d, i;
			int          dr, dg, db;
			limit = searched();
			m = '{index: '0, none: 1'b1, dist_sq: '0};
			for (i = 0; i < limit; i++) begin
				dr = int'(r) - int'(entries[i][23:16]);
				dg = int'(g) - int'(entries[i][15:8]);
				db = int'(b) - int'(entries[i][7:0]);
				d = dr * dr + dg * dg + db * db;
				if (m.none || d < m.dist_sq) begin
					m.index = i[IDX_W-1:0];
					m.none = 1'b0;
					m.dist_sq = d[DIST_W-1:0];
				end
			end
			return m;
		endfunction

		function void take_item(logic kind, logic [IDX_W-1:0] slot, logic [CH_W-1:0] r,
				logic [CH_W-1:0] g, logic [CH_W-1:0] b);
			if (kind == OP_WRITE) begin
				if (slot < NUM_ENTRIES)
					entries[slot] = {r, g, b};
			end else begin
				pending_matches.push_back(nearest_entry(r, g, b));
			end
		endfunction

		function void check_match(match_t got);
			match_t want;
			if (pending_matches.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %0d/%0d/%0d",
					$time, got.index, got.none, got.dist_sq);
				failures++;
				return;
			end
			want = pending_matches.pop_front();
			if (got.index !== want.index) begin
				$display("%0t: nearest_index expected %0d, got %0d",
					$time, want.index, got.index);
				failures++;
			end
			if (got.none !== want.none) begin
				$display("%0t: no_match expected %0d, got %0d", $time, want.none, got.none);
				failures++;
			end
			if (got.dist_sq !== want.dist_sq) begin
				$display("%0t: nearest_dist_sq expected %0d, got %0d",
					$time, want.dist_sq, got.dist_sq);
				failures++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CNT_W-1:0]  cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              op = OP_WRITE;
	logic [IDX_W-1:0]  entry_index = '0;
	logic [CH_W-1:0]   red_in = '0;
	logic [CH_W-1:0]   green_in = '0;
	logic [CH_W-1:0]   blue_in = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [IDX_W-1:0]  nearest_index;
	logic              no_match;
	logic [DIST_W-1:0] nearest_dist_sq;

	palette_mirror board = new();
	int unsigned   burst_left = 0;
	int unsigned   hold_requests = 0;
	int unsigned   holds_served = 0;
	int unsigned   hold_left = 0;
	int unsigned   mode_left = 0;
	int unsigned   ready_mode = 0;
	longint        cycle_count = 0;

	nearest_palette_color #(
		.NUM_ENTRIES(NUM_ENTRIES)
	) uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.entry_index    (entry_index),
		.red_in         (red_in),
		.green_in       (green_in),
		.blue_in        (blue_in),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.nearest_index  (nearest_index),
		.no_match       (no_match),
		.nearest_dist_sq(nearest_dist_sq)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready)
			board.check_match('{nearest_index, no_match, nearest_dist_sq});
		if (hold_requests != holds_served) begin
			holds_served++;
			hold_left = HOLD_CYCLES;
		end
		if (mode_left == 0) begin
			mode_left = $urandom_range(20, 200);
			ready_mode = $urandom_range(0, 3);
		end else begin
			mode_left--;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			case (ready_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 1) == 1);
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	task automatic pace_sender();
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	task automatic send_item(input logic kind, input logic [IDX_W-1:0] slot,
			input logic [CH_W-1:0] r, input logic [CH_W-1:0] g, input logic [CH_W-1:0] b);
		in_valid <= 1'b1;
		op <= kind;
		entry_index <= slot;
		red_in <= r;
		green_in <= g;
		blue_in <= b;
		do @(posedge clk); while (!in_ready);
		board.take_item(kind, slot, r, g, b);
		pace_sender();
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (board.pending_matches.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_count(input logic [CNT_W-1:0] value);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.set_count(value);
	endtask

	function automatic logic [CH_W-1:0] nudge(logic [CH_W-1:0] c);
		int v;
		v = int'(c) + int'($urandom_range(0, 6)) - 3;
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return v[CH_W-1:0];
	endfunction

	task automatic random_item();
		logic [CH_W-1:0]    r, g, b;
		logic [COLOR_W-1:0] e;
		int unsigned        lim;
		r = CH_W'($urandom_range(0, 255));
		g = CH_W'($urandom_range(0, 255));
		b = CH_W'($urandom_range(0, 255));
		if ($urandom_range(0, 4) == 0) begin
			send_item(OP_WRITE, IDX_W'($urandom_range(0, NUM_ENTRIES - 1)), r, g, b);
		end else begin
			lim = board.searched();
			if (lim != 0 && $urandom_range(0, 1) == 1) begin
				e = board.entries[IDX_W'($urandom_range(0, lim - 1))];
				r = nudge(e[23:16]);
				g = nudge(e[15:8]);
				b = nudge(e[7:0]);
			end
			send_item(OP_CLASSIFY, IDX_W'($urandom_range(0, 15)), r, g, b);
		end
	endtask

	initial begin
		int               s, p, n;
		logic [CNT_W-1:0] c;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty palette after reset
		send_item(OP_CLASSIFY, 4'hF, 8'h00, 8'h00, 8'h00);
		send_item(OP_CLASSIFY, 4'h0, 8'hFF, 8'hFF, 8'hFF);
		send_item(OP_WRITE, 4'd0, 8'h00, 8'h00, 8'h00);
		send_item(OP_WRITE, 4'd1, 8'hFF, 8'hFF, 8'hFF);
		send_item(OP_WRITE, 4'd2, 8'hFF, 8'h00, 8'h00);
		send_item(OP_WRITE, 4'd3, 8'h00, 8'hFF, 8'h00);
		send_item(OP_WRITE, 4'd4, 8'h00, 8'h00, 8'hFF);
		send_item(OP_WRITE, 4'd5, 8'hFF, 8'h00, 8'h00);
		for (s = 6; s < NUM_ENTRIES; s++)
			send_item(OP_WRITE, s[IDX_W-1:0], CH_W'(s * 25), CH_W'(255 - s * 15),
				CH_W'(s * 11));

		write_count(5'd16);
		send_item(OP_CLASSIFY, 4'd3, 8'hFF, 8'hFF, 8'hFF);
		send_item(OP_CLASSIFY, 4'd9, 8'h00, 8'h00, 8'h00);
		// tie between equal entries: lower slot wins
		send_item(OP_CLASSIFY, 4'd7, 8'hFF, 8'h00, 8'h00);
		send_item(OP_CLASSIFY, 4'd12, 8'h80, 8'h40, 8'hC0);
		write_count(5'd1);
		send_item(OP_CLASSIFY, 4'd5, 8'hFF, 8'hFF, 8'hFF);
		// count beyond the palette saturates
		write_count(5'd31);
		send_item(OP_CLASSIFY, 4'd10, 8'hFF, 8'h01, 8'h02);

		for (p = 0; p < 8; p++) begin
			case (p)
				0: c = 5'd16;
				1: c = CNT_W'($urandom_range(2, 15));
				2: c = 5'd31;
				3: c = 5'd1;
				4: c = CNT_W'($urandom_range(2, 15));
				5: c = 5'd0;
				6: c = 5'd17;
				default: c = CNT_W'($urandom_range(18, 30));
			endcase
			write_count(c);
			if (p == 0)
				hold_requests <= hold_requests + 1;
			for (n = 0; n < PHASE_ITEMS; n++)
				random_item();
		end

		settle();
		if (board.failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
